// ===== src/assert_macros.svh =====
// Assertion macros shared by the weighted moving average RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset
`define WMA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("weighted_moving_average: assertion failed");
// Condition followed by a consequence in the next cycle
`define WMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_moving_average: assertion failed");
`else
`define WMA_ASSERT(label, prop)
`define WMA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/wma_pkg.sv =====
// Shared constants and types for the weighted moving average block.
// No dependencies; used by wma_div, weighted_moving_average and the testbench.
`default_nettype none
package wma_pkg;

  // Field and port widths
  localparam int PRICE_W    = 32;
  localparam int WIN_W      = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register map
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_ADDR = 2'd0;
  localparam logic [WIN_W-1:0]      WINDOW_RESET    = 7'd1;

  // Default depth of the price history
  localparam int MAX_WINDOW_DEF = 64;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== src/wma_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
// Depends on wma_pkg (control/status structs) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wma_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire wma_pkg::div_ctrl_t    ctrl,
  input  wire logic [NUM_W-1:0]      numerator,
  input  wire logic [DEN_W-1:0]      denominator,
  output wma_pkg::div_stat_t         stat,
  output logic      [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             q_bit;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    q_bit   = ~diff[DEN_W];
  end

  // Control: counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (ctrl.start && !busy_r) begin
      quo_r <= numerator;
      rem_r <= '0;
      den_r <= denominator;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], q_bit};
      rem_r <= q_bit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  // Checks
  `WMA_ASSERT(a_div_den_nonzero, busy_r |-> (den_r != '0))
  `WMA_ASSERT_NEXT(a_div_done_pulse, done_r, !done_r && !busy_r)
  `WMA_ASSERT(a_div_cnt_live, busy_r |-> (cnt_r != '0))

endmodule
`default_nettype wire

// ===== src/weighted_moving_average.sv =====
// Linearly weighted moving average of unsigned Q16.16 prices.
// Uses wma_pkg, wma_div and assert_macros.svh.
//
// Usage:
//   Input channel: in_valid / in_stall with in_close_price (Q16.16) and
//   in_series_start, which clears the history before taking the price.
//   Result channel: out_valid / out_stall with out_average (Q16.16,
//   truncated) and out_average_valid. One result per item, in order.
//   While fewer than N prices of a series have arrived the result is 0 with
//   out_average_valid low. N is set through the APB register at byte
//   address 0 (window_length, 0 acts as 1, values above MAX_WINDOW clamp);
//   a write also clears the history. Write it only while the block is idle.
// Timing:
//   A valid average passes through S_READ, S_UPDATE, S_START, S_DIV and
//   S_DONE after acceptance before it reaches the output register, and the
//   next item is taken only once the block is back in S_IDLE; the bit-serial
//   divider, one quotient bit per cycle, works in S_DIV. Without a valid average S_START and S_DIV are skipped.
//   in_stall is high after acceptance until the result reaches the output
//   register; a stalled result waits there while one more item is worked.
//   Reset sets N to 1 and empties the history; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module weighted_moving_average #(
  parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [wma_pkg::PRICE_W-1:0]       in_close_price,
  input  wire logic                              in_series_start,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [wma_pkg::PRICE_W-1:0]       out_average,
  output logic                                   out_average_valid,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [wma_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [wma_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [wma_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int PRICE_W = wma_pkg::PRICE_W;
  localparam int WIN_W   = wma_pkg::WIN_W;
  localparam int NW      = $clog2(MAX_WINDOW + 1);
  localparam int PW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PS_W    = NW + 1;
  localparam int DV_W    = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
  localparam int SUM_W   = PRICE_W + NW;
  localparam int WSUM_W  = PRICE_W + DV_W;
  localparam int PROD_W  = PRICE_W + NW;
  localparam int TRI_W   = 2 * NW + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_START  = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WIN_W-1:0]     window_r;
  logic [PW-1:0]        wp_r;
  logic [NW-1:0]        seen_r;
  logic [SUM_W-1:0]     sum_r;
  logic [WSUM_W-1:0]    wsum_r;
  logic [PRICE_W-1:0]   price_r;
  logic [PROD_W-1:0]    product_r;
  logic [DV_W-1:0]      divisor_r;
  logic [PRICE_W-1:0]   rd_data_r;
  logic                 avg_valid_r;
  logic                 out_valid_r;
  logic [PRICE_W-1:0]   out_average_r;
  logic                 out_average_valid_r;
  logic [PRICE_W-1:0]   history [MAX_WINDOW];

  logic                 in_accept;
  logic                 cfg_write;
  logic                 out_free;
  logic [NW-1:0]        n_eff;
  logic [TRI_W-1:0]     tri_prod;
  logic [PS_W-1:0]      pos_raw;
  logic [PW-1:0]        rd_pos;
  logic                 full;
  logic [NW-1:0]        seen_nxt;
  logic [SUM_W-1:0]     sum_nxt;
  logic [WSUM_W-1:0]    wsum_nxt;
  logic [PW-1:0]        wp_nxt;

  wma_pkg::div_ctrl_t   div_ctrl;
  wma_pkg::div_stat_t   div_stat;
  logic [WSUM_W-1:0]    div_quo;

  // Handshakes
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == wma_pkg::REG_WINDOW_ADDR);
  assign pready    = 1'b1;
  assign prdata    = (paddr == wma_pkg::REG_WINDOW_ADDR) ?
                     wma_pkg::CFG_DATA_W'(window_r) : '0;

  // Effective window: 0 acts as 1, clamp to the history depth
  always_comb begin
    if (window_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(window_r);
    end
  end

  // Divisor N(N+1)/2 and the ring position of the oldest price
  always_comb begin
    tri_prod = TRI_W'(n_eff) * (TRI_W'(n_eff) + TRI_W'(1));
    pos_raw  = PS_W'(wp_r) + PS_W'(MAX_WINDOW) - PS_W'(n_eff);
    if (pos_raw >= PS_W'(MAX_WINDOW)) begin
      rd_pos = PW'(pos_raw - PS_W'(MAX_WINDOW));
    end else begin
      rd_pos = PW'(pos_raw);
    end
  end

  // Running sums update
  always_comb begin
    full     = (seen_r >= n_eff);
    seen_nxt = full ? seen_r : seen_r + NW'(1);
    sum_nxt  = sum_r + SUM_W'(price_r) - (full ? SUM_W'(rd_data_r) : SUM_W'(0));
    wsum_nxt = wsum_r - WSUM_W'(sum_r) + WSUM_W'(product_r);
    wp_nxt   = (32'(wp_r) == MAX_WINDOW - 1) ? '0 : wp_r + PW'(1);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_accept) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = (seen_nxt >= n_eff) ? S_START : S_DONE;
      S_START:  state_nxt = S_DIV;
      S_DIV:    if (div_stat.done) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign div_ctrl.start = (state_r == S_START);

  // Control state and series registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= wma_pkg::WINDOW_RESET;
      wp_r     <= '0;
      seen_r   <= '0;
      sum_r    <= '0;
      wsum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) begin
        window_r <= pwdata[WIN_W-1:0];
      end
      if (cfg_write || (in_accept && in_series_start)) begin
        wp_r   <= '0;
        seen_r <= '0;
        sum_r  <= '0;
        wsum_r <= '0;
      end else if (state_r == S_UPDATE) begin
        wp_r   <= wp_nxt;
        seen_r <= seen_nxt;
        sum_r  <= sum_nxt;
        wsum_r <= wsum_nxt;
      end
    end
  end

  // Per-item payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      price_r <= in_close_price;
    end
    if (state_r == S_READ) begin
      product_r <= PROD_W'(n_eff) * PROD_W'(price_r);
      divisor_r <= DV_W'(tri_prod >> 1);
    end
    if (state_r == S_UPDATE) begin
      avg_valid_r <= (seen_nxt >= n_eff);
    end
  end

  // Price history ring: read the oldest price, then write the new one
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_data_r <= history[rd_pos];
    end
    if (state_r == S_UPDATE) begin
      history[wp_r] <= price_r;
    end
  end

  // Divider
  wma_div #(
    .NUM_W (WSUM_W),
    .DEN_W (DV_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (div_ctrl),
    .numerator   (wsum_r),
    .denominator (divisor_r),
    .stat        (div_stat),
    .quotient    (div_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_average_r       <= avg_valid_r ? div_quo[PRICE_W-1:0] : '0;
      out_average_valid_r <= avg_valid_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average       = out_average_r;
  assign out_average_valid = out_average_valid_r;

  // Checks
  `WMA_ASSERT(a_seen_bounded, seen_r <= n_eff)
  `WMA_ASSERT(a_div_running, (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
  `WMA_ASSERT(a_invalid_zero, (out_valid_r && !out_average_valid_r) |-> (out_average_r == '0))
  `WMA_ASSERT(a_div_idle_outside, (state_r == S_IDLE) |-> !div_stat.busy)

endmodule
`default_nettype wire

// ===== tb/weighted_moving_average_test.sv =====
// Self-checking testbench for weighted_moving_average: directed table, then random series.
// Depends on wma_pkg and the weighted_moving_average RTL, which in turn needs wma_div and assert_macros.svh.
`default_nettype none
module weighted_moving_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH    = 64;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLDOFF_LEN   = 400;
  localparam int DRAIN_CYCLES  = 60;
  localparam int MAX_REPORTS   = 10;

  // Directed table rows: either an item or a window_length write
  typedef enum logic {ROW_ITEM, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;      // price, or window write data
    logic        start;
    logic        check;      // use the typed-in expectation
    logic [31:0] exp_avg;
    logic        exp_valid;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] avg;
    logic        valid;
  } average_t;

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // after reset N is 1: average equals the price
    '{ROW_ITEM,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_ITEM,   32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{ROW_ITEM,   32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b1},
    // N = 2: first price not valid yet
    '{ROW_WINDOW, 32'd2,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0001_0000, 1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0002_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
    // series start empties the window
    '{ROW_ITEM,   32'h0000_0005, 1'b1, 1'b1, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_0007, 1'b0, 1'b0, 32'h0,         1'b0},
    // zero window acts as one
    '{ROW_WINDOW, 32'd0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'hABCD_0000, 1'b0, 1'b1, 32'hABCD_0000, 1'b1},
    '{ROW_ITEM,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    // largest window
    '{ROW_WINDOW, 32'd64,        1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_0001, 1'b0, 1'b1, 32'h0,         1'b0},
    // oversized window clamps to the history depth
    '{ROW_WINDOW, 32'd127,       1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_0001, 1'b0, 1'b1, 32'h0,         1'b0},
    // N = 3, then a restart in the middle of the series
    '{ROW_WINDOW, 32'd3,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_0009, 1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_0003, 1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_0006, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h0000_000C, 1'b1, 1'b1, 32'h0,         1'b0},
    // a window write clears the history too
    '{ROW_WINDOW, 32'd1,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_ITEM,   32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [wma_pkg::PRICE_W-1:0]    in_close_price = '0;
  logic                           in_series_start = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [wma_pkg::PRICE_W-1:0]    out_average;
  logic                           out_average_valid;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [wma_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [wma_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [wma_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  weighted_moving_average u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_close_price    (in_close_price),
    .in_series_start   (in_series_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_average       (out_average),
    .out_average_valid (out_average_valid),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Predictor state
  logic [31:0] price_ring [HIST_DEPTH];
  logic [5:0]  ring_wr;
  logic [6:0]  prices_in_series;
  logic [63:0] plain_sum;
  logic [63:0] wtd_total;
  logic [6:0]  window_reg = wma_pkg::WINDOW_RESET;

  average_t pending_averages [$];

  int  mismatches       = 0;
  int  items_sent       = 0;
  int  averages_checked = 0;
  int  valid_averages   = 0;
  int  windows_written  = 0;
  bit  calm_phase       = 1'b0;
  bit  holdoff_done     = 1'b0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [6:0] effective_window(logic [6:0] w);
    if (w == 7'd0) return 7'd1;
    if (w > 7'(HIST_DEPTH)) return 7'(HIST_DEPTH);
    return w;
  endfunction

  function automatic int draw_gap();
    return calm_phase ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic void clear_history();
    ring_wr = '0;
    prices_in_series = '0;
    plain_sum = '0;
    wtd_total = '0;
  endfunction

  // Running-sum update for one price; returns the expected result
  function automatic average_t predict_average(logic [31:0] price, logic start);
    logic [6:0]  n;
    logic [5:0]  oldest;
    logic [63:0] divisor;
    average_t    res;
    n = effective_window(window_reg);
    if (start) clear_history();
    wtd_total = wtd_total - plain_sum + 64'(n) * 64'(price);
    plain_sum = plain_sum + 64'(price);
    if (prices_in_series >= n) begin
      oldest = ring_wr - n[5:0];
      plain_sum = plain_sum - 64'(price_ring[oldest]);
    end else begin
      prices_in_series = prices_in_series + 7'd1;
    end
    price_ring[ring_wr] = price;
    ring_wr = ring_wr + 6'd1;
    if (prices_in_series >= n) begin
      divisor = (64'(n) * (64'(n) + 64'd1)) / 64'd2;
      res.avg = 32'(wtd_total / divisor);
      res.valid = 1'b1;
    end else begin
      res.avg = '0;
      res.valid = 1'b0;
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, exp_v, act_v);
  endfunction

  // Offer one item and hold it until accepted
  task automatic push_item(logic [31:0] price, logic start, logic use_table,
                           logic [31:0] exp_avg, logic exp_valid);
    int       gap;
    average_t res;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_close_price  <= price;
    in_series_start <= start;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = predict_average(price, start);
    if (use_table) begin
      res.avg = exp_avg;
      res.valid = exp_valid;
    end
    pending_averages = {pending_averages, res};
    items_sent++;
  endtask

  // Write window_length once the block has drained, then read it back
  task automatic write_window(logic [31:0] value);
    logic [31:0] rd;
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wma_pkg::REG_WINDOW_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {25'd0, value[6:0]}) report_mismatch("window_length readback", {25'd0, value[6:0]}, rd);
    window_reg = value[6:0];
    clear_history();
    windows_written++;
  endtask

  // Stimulus: reset, directed table, random series
  initial begin
    logic [31:0] wdata;
    logic [31:0] price;
    logic [6:0]  n_eff;
    bit          max_run;
    bit          noisy;
    int          phase_len;
    clear_history();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WINDOW)
        write_window(DIRECTED[i].value);
      else
        push_item(DIRECTED[i].value, DIRECTED[i].start, DIRECTED[i].check,
                  DIRECTED[i].exp_avg, DIRECTED[i].exp_valid);
    end

    while (items_sent < RANDOM_ITEMS + N_DIRECTED) begin
      calm_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       wdata = 32'd64;
        1:       wdata = 32'd1;
        2:       wdata = 32'd0;
        3:       wdata = 32'($urandom_range(65, 127));
        4, 5, 6: wdata = 32'($urandom_range(2, 8));
        default: wdata = 32'($urandom_range(9, 63));
      endcase
      // junk in the unused upper data bits now and then
      if ($urandom_range(0, 1) == 1) wdata = {25'($urandom() >> 7), wdata[6:0]};
      write_window(wdata);
      n_eff = effective_window(wdata[6:0]);
      max_run = ($urandom_range(0, 9) == 0);
      noisy = ($urandom_range(0, 4) == 0);
      phase_len = 2 * int'(n_eff) + int'($urandom_range(8, 40));
      for (int k = 0; k < phase_len; k++) begin
        if (max_run) begin
          price = 32'hFFFF_FFFF;
        end else begin
          case ($urandom_range(0, 9))
            0:       price = 32'hFFFF_FFFF;
            1:       price = 32'h0;
            2:       price = 32'($urandom_range(0, 255));
            default: price = $urandom();
          endcase
        end
        push_item(price, noisy ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 99) == 0),
                  1'b0, 32'h0, 1'b0);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow a few more cycles for anything stray
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items across %0d window_length writes (0, 1, 64 and clamped among them).",
             items_sent, windows_written);
    $display("Checked %0d averages, %0d of them valid; %0d mismatches.",
             averages_checked, valid_averages, mismatches);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, in-order compare
  initial begin
    int       gap;
    average_t exp_res;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      if (!holdoff_done && averages_checked >= 300 && in_valid === 1'b1) begin
        holdoff_done = 1'b1;
        gap = HOLDOFF_LEN;
      end else begin
        gap = draw_gap();
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_averages.size() == 0) begin
        report_mismatch("unexpected result, average", 32'h0, out_average);
      end else begin
        exp_res = pending_averages.pop_front();
        if (out_average !== exp_res.avg)
          report_mismatch("average", exp_res.avg, out_average);
        if (out_average_valid !== exp_res.valid)
          report_mismatch("average_valid", 32'(exp_res.valid), 32'(out_average_valid));
        if (exp_res.valid) valid_averages++;
        averages_checked++;
      end
    end
  end

  // Watchdog: too long without any handshake or register access
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (psel === 1'b1 && penable === 1'b1) || rst_n !== 1'b1)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
